// ===== rtl/lfu_pkg.sv =====
`timescale 1ns / 1ps

package lfu_pkg;

   // Default sizes of the table.
   localparam int LFU_CAPACITY    = 16;
   localparam int LFU_COUNT_WIDTH = 16;

   // Fixed field widths.
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int LIMIT_WIDTH = 5;

   // Entry limit after reset.
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 5'd16;

   // Command codes.
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // One request word.
   typedef struct packed {
      logic                          command;
      logic signed [KEY_WIDTH-1:0]   key;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   // One response word.
   typedef struct packed {
      logic                          found;
      logic signed [VALUE_WIDTH-1:0] read_value;
      logic                          evicted;
      logic signed [KEY_WIDTH-1:0]   evicted_key;
   } rsp_type;

   // What the scan pass has seen so far.
   typedef struct packed {
      logic hit;
      logic victim;
      logic free;
   } scan_flags_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/lfu_cache_table.sv =====
`timescale 1ns / 1ps

// Channel    Ports                          Transfer
// request    start, busy, req_data          taken when start is high and busy is low
// response   rsp_strobe, rsp_data           one word per request, valid for one cycle
// control    csr_we, csr_wdata              entry limit, written when csr_we is high
//
// A get that misses makes a single lookup pass over the entry memory; every other
// request makes two passes, one entry read per cycle: a lookup pass, then a
// read-modify-write pass. With the limit at zero the response follows in the cycle
// after acceptance.
// The next request can be taken in the cycle of the response strobe.
// Reset is synchronous and clears the valid bits, the occupancy and the sequencer.
// The response side cannot stall.

module lfu_cache_table #(
   parameter int CAPACITY    = lfu_pkg::LFU_CAPACITY,
   parameter int COUNT_WIDTH = lfu_pkg::LFU_COUNT_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  lfu_pkg::req_type                 req_data,
   output logic                             busy,
   output logic                             rsp_strobe,
   output lfu_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [lfu_pkg::LIMIT_WIDTH-1:0]  csr_wdata
);

   import lfu_pkg::*;

   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int LIM_W   = (CNT_W > LIMIT_WIDTH) ? CNT_W : LIMIT_WIDTH;
   localparam int ENTRY_W = KEY_WIDTH + VALUE_WIDTH + COUNT_WIDTH + IDX_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   rsp_type                rsp_ff, rsp_in;
   logic [LIMIT_WIDTH-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0]       occ_ff, occ_in;
   logic [CAPACITY-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]       sp_idx_ff, sp_idx_in;
   logic                   sp_en_ff, sp_en_in;
   logic                   ins_ff, ins_in;
   logic [IDX_W-1:0]       thr_ff, thr_in;
   logic                   age_all_ff, age_all_in;

   logic                   accept;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [ENTRY_W-1:0]     rd_data;
   logic                   wr_en;
   logic [ENTRY_W-1:0]     wr_data;
   logic                   last;

   logic [KEY_WIDTH-1:0]   rd_key;
   logic [VALUE_WIDTH-1:0] rd_value;
   logic [COUNT_WIDTH-1:0] rd_count;
   logic [IDX_W-1:0]       rd_rank;

   logic [LIM_W-1:0]       cap_ext;
   logic [LIM_W-1:0]       lim;
   logic                   lim_zero;

   scan_flags_type         flags;
   logic [IDX_W-1:0]       hit_idx, hit_rank, vic_idx, vic_rank, free_idx;
   logic [VALUE_WIDTH-1:0] hit_value;
   logic [KEY_WIDTH-1:0]   vic_key;

   logic                   need_evict;
   logic                   slot_ok;
   logic [IDX_W-1:0]       slot_idx;
   logic                   upd;
   logic                   is_sp;
   logic                   age;
   logic [ENTRY_W-1:0]     sp_word;

   // Entry word layout: key, value, use count, recency rank.
   assign rd_key   = rd_data[ENTRY_W-1 -: KEY_WIDTH];
   assign rd_value = rd_data[ENTRY_W-KEY_WIDTH-1 -: VALUE_WIDTH];
   assign rd_count = rd_data[IDX_W +: COUNT_WIDTH];
   assign rd_rank  = rd_data[IDX_W-1:0];

   // Effective limit is the register clipped to the table size.
   assign cap_ext  = LIM_W'(cap_ff);
   assign lim      = (cap_ext > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : cap_ext;
   assign lim_zero = (lim == '0);

   assign accept = start && !busy;
   assign last   = rd_vld_ff && (rd_idx_ff == IDX_W'(CAPACITY - 1));

   lfu_entry_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rd_idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lfu_scan #(
      .CAPACITY    (CAPACITY),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_scan (
      .clock       (clock),
      .clear       (accept),
      .sample      ((state_ff == ST_SCAN) && rd_vld_ff),
      .idx         (rd_idx_ff),
      .entry_valid (valid_ff[rd_idx_ff]),
      .entry_key   (rd_key),
      .entry_value (rd_value),
      .entry_count (rd_count),
      .entry_rank  (rd_rank),
      .lookup_key  (req_ff.key),
      .flags       (flags),
      .hit_idx     (hit_idx),
      .hit_value   (hit_value),
      .hit_rank    (hit_rank),
      .vic_idx     (vic_idx),
      .vic_key     (vic_key),
      .vic_rank    (vic_rank),
      .free_idx    (free_idx)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_RESP: begin
            if (accept) begin
               state_in = lim_zero ? ST_RESP : ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (flags.hit || (req_ff.command == CMD_PUT)) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_UPDATE: begin
            if (last) begin
               state_in = ST_RESP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy       = 1'b0;
      rsp_strobe = 1'b0;
      rd_en      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_SCAN, ST_UPDATE: begin
            busy  = 1'b1;
            rd_en = (cnt_ff < CNT_W'(CAPACITY));
         end
         ST_DECIDE: begin
            busy = 1'b1;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = cnt_ff[IDX_W-1:0];

   // Read address counter and the tag that follows the read data.
   always_comb begin
      cnt_in    = cnt_ff;
      rd_vld_in = rd_en;
      rd_idx_in = rd_addr;
      if (accept || (state_ff == ST_DECIDE)) begin
         cnt_in = '0;
      end else if (rd_en) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // Victim and free slot choice for a put that misses.
   always_comb begin
      need_evict = (LIM_W'(occ_ff) >= lim) && flags.victim;
      slot_ok    = 1'b0;
      slot_idx   = free_idx;
      if (need_evict) begin
         slot_ok = 1'b1;
         if (!(flags.free && (free_idx < vic_idx))) begin
            slot_idx = vic_idx;
         end
      end else if (flags.free) begin
         slot_ok = 1'b1;
      end
   end

   // Decision after the lookup pass: response word, bookkeeping, update plan.
   always_comb begin
      req_in     = req_ff;
      rsp_in     = rsp_ff;
      cap_in     = cap_ff;
      occ_in     = occ_ff;
      valid_in   = valid_ff;
      sp_idx_in  = sp_idx_ff;
      sp_en_in   = sp_en_ff;
      ins_in     = ins_ff;
      thr_in     = thr_ff;
      age_all_in = age_all_ff;
      if (csr_we) begin
         cap_in = csr_wdata;
      end
      if (accept) begin
         req_in = req_data;
         rsp_in = '0;
      end
      if (state_ff == ST_DECIDE) begin
         if (flags.hit) begin
            rsp_in.found      = 1'b1;
            rsp_in.read_value = (req_ff.command == CMD_GET) ? hit_value : '0;
            sp_idx_in         = hit_idx;
            sp_en_in          = 1'b1;
            ins_in            = 1'b0;
            thr_in            = hit_rank;
            age_all_in        = 1'b0;
         end else if (req_ff.command == CMD_PUT) begin
            rsp_in.evicted     = need_evict;
            rsp_in.evicted_key = need_evict ? vic_key : '0;
            sp_idx_in          = slot_idx;
            sp_en_in           = slot_ok;
            ins_in             = 1'b1;
            thr_in             = vic_rank;
            age_all_in         = !need_evict;
            if (need_evict) begin
               valid_in[vic_idx] = 1'b0;
            end
            if (slot_ok) begin
               valid_in[slot_idx] = 1'b1;
            end
            occ_in = occ_ff - CNT_W'(need_evict) + CNT_W'(slot_ok);
         end
      end
   end

   // Write-back pass: rewrite the touched or new entry, age the newer ones.
   always_comb begin
      upd = (state_ff == ST_UPDATE) && rd_vld_ff;
      is_sp = sp_en_ff && (rd_idx_ff == sp_idx_ff);
      age = valid_ff[rd_idx_ff] && (age_all_ff || (rd_rank < thr_ff));
      sp_word = {ins_ff ? req_ff.key : rd_key,
                 (req_ff.command == CMD_PUT) ? req_ff.value : rd_value,
                 ins_ff ? COUNT_WIDTH'(1) :
                    ((rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_WIDTH'(1)),
                 IDX_W'(0)};
      wr_en = upd && (is_sp || age);
      wr_data = is_sp ? sp_word : {rd_key, rd_value, rd_count, rd_rank + IDX_W'(1)};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cap_ff    <= LIMIT_RESET;
         occ_ff    <= '0;
         valid_ff  <= '0;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cap_ff    <= cap_in;
         occ_ff    <= occ_in;
         valid_ff  <= valid_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      rd_idx_ff  <= rd_idx_in;
      sp_idx_ff  <= sp_idx_in;
      sp_en_ff   <= sp_en_in;
      ins_ff     <= ins_in;
      thr_ff     <= thr_in;
      age_all_ff <= age_all_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/lfu_entry_ram.sv =====
`timescale 1ns / 1ps

module lfu_entry_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 84
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/lfu_scan.sv =====
`timescale 1ns / 1ps

module lfu_scan #(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                              clock,
   input  logic                                              clear,
   input  logic                                              sample,
   input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] idx,
   input  logic                                              entry_valid,
   input  logic [lfu_pkg::KEY_WIDTH-1:0]                     entry_key,
   input  logic [lfu_pkg::VALUE_WIDTH-1:0]                   entry_value,
   input  logic [COUNT_WIDTH-1:0]                            entry_count,
   input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] entry_rank,
   input  logic [lfu_pkg::KEY_WIDTH-1:0]                     lookup_key,
   output lfu_pkg::scan_flags_type                           flags,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] hit_idx,
   output logic [lfu_pkg::VALUE_WIDTH-1:0]                   hit_value,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] hit_rank,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] vic_idx,
   output logic [lfu_pkg::KEY_WIDTH-1:0]                     vic_key,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] vic_rank,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] free_idx
);

   import lfu_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   scan_flags_type           flags_ff, flags_in;
   logic [IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   logic [VALUE_WIDTH-1:0]   hit_value_ff, hit_value_in;
   logic [IDX_W-1:0]         hit_rank_ff, hit_rank_in;
   logic [IDX_W-1:0]         vic_idx_ff, vic_idx_in;
   logic [KEY_WIDTH-1:0]     vic_key_ff, vic_key_in;
   logic [COUNT_WIDTH-1:0]   vic_count_ff, vic_count_in;
   logic [IDX_W-1:0]         vic_rank_ff, vic_rank_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic                     better;

   // An entry beats the current victim on a lower count, or on an equal count and older rank.
   assign better = (entry_count < vic_count_ff) ||
                   ((entry_count == vic_count_ff) && (entry_rank > vic_rank_ff));

   // Fold one entry into the running hit, victim and free-slot records.
   always_comb begin
      flags_in     = flags_ff;
      hit_idx_in   = hit_idx_ff;
      hit_value_in = hit_value_ff;
      hit_rank_in  = hit_rank_ff;
      vic_idx_in   = vic_idx_ff;
      vic_key_in   = vic_key_ff;
      vic_count_in = vic_count_ff;
      vic_rank_in  = vic_rank_ff;
      free_idx_in  = free_idx_ff;
      if (clear) begin
         flags_in = '0;
      end else if (sample) begin
         if (entry_valid) begin
            if (entry_key == lookup_key) begin
               flags_in.hit = 1'b1;
               hit_idx_in   = idx;
               hit_value_in = entry_value;
               hit_rank_in  = entry_rank;
            end
            if (!flags_ff.victim || better) begin
               flags_in.victim = 1'b1;
               vic_idx_in      = idx;
               vic_key_in      = entry_key;
               vic_count_in    = entry_count;
               vic_rank_in     = entry_rank;
            end
         end else if (!flags_ff.free) begin
            flags_in.free = 1'b1;
            free_idx_in   = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      flags_ff     <= flags_in;
      hit_idx_ff   <= hit_idx_in;
      hit_value_ff <= hit_value_in;
      hit_rank_ff  <= hit_rank_in;
      vic_idx_ff   <= vic_idx_in;
      vic_key_ff   <= vic_key_in;
      vic_count_ff <= vic_count_in;
      vic_rank_ff  <= vic_rank_in;
      free_idx_ff  <= free_idx_in;
   end

   assign flags     = flags_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_value = hit_value_ff;
   assign hit_rank  = hit_rank_ff;
   assign vic_idx   = vic_idx_ff;
   assign vic_key   = vic_key_ff;
   assign vic_rank  = vic_rank_ff;
   assign free_idx  = free_idx_ff;

endmodule
